// File: rtl/core/ssvs_pkg.sv
// Shared types, sizes and codes for the sorted sparse vector store.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps

package ssvs_pkg;

    // number of (coordinate, value) cells in the ring
    localparam int CAPACITY = 256;
    // register stages of the Q32.32 multiplier
    localparam int MUL_LAT  = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = $clog2(CAPACITY + MUL_LAT);

    // operation codes
    localparam logic [2:0] FN_GET   = 3'd0;
    localparam logic [2:0] FN_SET   = 3'd1;
    localparam logic [2:0] FN_INC   = 3'd2;
    localparam logic [2:0] FN_SCALE = 3'd3;
    localparam logic [2:0] FN_CLEAR = 3'd4;
    localparam logic [2:0] FN_READ  = 3'd5;

    // status codes
    localparam logic [2:0] STS_OK     = 3'd0;
    localparam logic [2:0] STS_RANGE  = 3'd1;
    localparam logic [2:0] STS_FULL   = 3'd2;
    localparam logic [2:0] STS_BADPOS = 3'd3;
    localparam logic [2:0] STS_SAT    = 3'd4;

    localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

    typedef logic [31:0] t_key;
    typedef logic [63:0] t_val;

    // multiplier output: the key that rode along, product and clamp flag
    typedef struct packed {
        t_key key;
        t_val q;
        logic sat;
    } t_mul_out;

endpackage

// File: rtl/core/ssvs_cell.sv
// One storage cell of the ring: a coordinate and its Q32.32 value.
// Depends on ssvs_pkg.
`timescale 1ns / 1ps

module ssvs_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  ssvs_pkg::t_key i_key,
    input  ssvs_pkg::t_val i_val,
    output ssvs_pkg::t_key o_key,
    output ssvs_pkg::t_val o_val
);
    import ssvs_pkg::*;

    t_key r_key;
    t_val r_val;

    // take the neighbor's pair while the ring rotates, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key <= i_key;
            r_val <= i_val;
        end
    end

    assign o_key = r_key;
    assign o_val = r_val;

endmodule

// File: rtl/core/ssvs_qmul.sv
// Five-stage signed Q32.32 multiplier with floor rounding and saturation.
// Carries a coordinate alongside; depends on ssvs_pkg.
`timescale 1ns / 1ps

module ssvs_qmul (
    input  logic                i_clk,
    input  ssvs_pkg::t_key      i_key,
    input  ssvs_pkg::t_val      i_a,
    input  ssvs_pkg::t_val      i_b,
    output ssvs_pkg::t_mul_out  o_res
);
    import ssvs_pkg::*;

    t_key        r_key_dly [MUL_LAT];
    logic [63:0] r1_ma, r1_mb;
    logic        r1_neg, r2_neg, r3_neg, r4_neg;
    logic [63:0] r2_p00, r2_p01, r2_p10, r2_p11;
    logic [33:0] r3_mid;
    logic [63:0] r3_hip;
    logic [31:0] r3_lo32;
    logic [63:0] r4_hi, r4_lo;
    t_val        r5_q;
    logic        r5_sat;

    logic [63:0] q;
    logic        over, frac_nz;
    t_val        n_q;
    logic        n_sat;

    // stage 5: floor rounding on magnitudes, then sign and clamp
    always_comb begin
        over    = |r4_hi[63:32];
        q       = {r4_hi[31:0], r4_lo[63:32]};
        frac_nz = |r4_lo[31:0];
        n_sat   = 1'b0;
        n_q     = q;
        if (over) begin
            n_sat = 1'b1;
            n_q   = r4_neg ? VAL_MIN : VAL_MAX;
        end else if (!r4_neg) begin
            if (q[63]) begin
                n_sat = 1'b1;
                n_q   = VAL_MAX;
            end
        end else if (frac_nz) begin
            // -(q + 1) is ~q
            if (q[63]) begin
                n_sat = 1'b1;
                n_q   = VAL_MIN;
            end else begin
                n_q = ~q;
            end
        end else begin
            if (q[63] && (|q[62:0])) begin
                n_sat = 1'b1;
                n_q   = VAL_MIN;
            end else begin
                n_q = 64'd0 - q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: magnitudes
        r1_ma  <= i_a[63] ? (64'd0 - i_a) : i_a;
        r1_mb  <= i_b[63] ? (64'd0 - i_b) : i_b;
        r1_neg <= i_a[63] ^ i_b[63];
        // stage 2: four 32x32 partial products
        r2_p00 <= r1_ma[31:0]  * r1_mb[31:0];
        r2_p01 <= r1_ma[31:0]  * r1_mb[63:32];
        r2_p10 <= r1_ma[63:32] * r1_mb[31:0];
        r2_p11 <= r1_ma[63:32] * r1_mb[63:32];
        r2_neg <= r1_neg;
        // stage 3: middle column and partial high word
        r3_mid  <= {2'b00, r2_p00[63:32]} + {2'b00, r2_p01[31:0]} + {2'b00, r2_p10[31:0]};
        r3_hip  <= r2_p11 + {32'd0, r2_p01[63:32]} + {32'd0, r2_p10[63:32]};
        r3_lo32 <= r2_p00[31:0];
        r3_neg  <= r2_neg;
        // stage 4: assemble the 128-bit magnitude
        r4_hi  <= r3_hip + {62'd0, r3_mid[33:32]};
        r4_lo  <= {r3_mid[31:0], r3_lo32};
        r4_neg <= r3_neg;
        // stage 5
        r5_q   <= n_q;
        r5_sat <= n_sat;
        // coordinate delay line
        r_key_dly[0] <= i_key;
        for (int k = 1; k < MUL_LAT; k++) begin
            r_key_dly[k] <= r_key_dly[k-1];
        end
    end

    assign o_res.key = r_key_dly[MUL_LAT-1];
    assign o_res.q   = r5_q;
    assign o_res.sat = r5_sat;

endmodule

// File: rtl/core/sorted_sparse_vector_store_unit.sv
// Top level of the sorted sparse vector store: control, ring of cells, multiplier.
// Depends on ssvs_pkg, ssvs_cell and ssvs_qmul.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ------------------------------------
//  request   in         i_in_valid / o_in_stall    i_func, i_index, i_operand
//  result    out        o_out_valid / i_out_stall  o_result_value, o_result_index,
//                                                  o_found, o_slot, o_entry_count, o_status
//  config    in         i_cfg_we                   i_cfg_wdata (vector_length)
//
//  get, set, inc and read-at-slot rotate the ring once; scale rotates the ring plus
//  the MUL_LAT multiplier stages. Clear, out-of-range, bad slot and unused codes
//  skip the scan and go straight to the result.
//  i_rst_n (synchronous, active low) empties the store and zeroes vector_length.
//  A stalled result holds in the output register; one more request is taken meanwhile
//  and its result waits until the register frees.
//
// The store is a ring of CAPACITY cells kept sorted by coordinate from cell 0.
// During a scan every cell hands its pair to its lower neighbor each cycle and the
// pair leaving cell 0 is inspected, possibly rewritten, and fed back into the top
// cell. After a full rotation every pair is back in place. An insert emits the new
// pair in front of the first pair whose coordinate is not below it and delays every
// later pair by one through a carry register, which shifts the tail up by one slot.

module sorted_sparse_vector_store_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [32:0]        i_cfg_wdata,
    // request
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_func,
    input  logic [31:0]        i_index,
    input  logic signed [63:0] i_operand,
    // result
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_result_value,
    output logic [31:0]        o_result_index,
    output logic               o_found,
    output logic [7:0]         o_slot,
    output logic [8:0]         o_entry_count,
    output logic [2:0]         o_status
);
    import ssvs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    t_state           r_state;
    logic [32:0]      r_vec_len;
    logic [CNT_W-1:0] r_count;
    logic [POS_W-1:0] r_pos;
    logic             r_decided;
    logic             r_carry_on;
    logic             r_sat;
    t_key             r_carry_key;
    t_val             r_carry_val;

    // latched request
    logic [2:0]       r_func;
    t_key             r_idx;
    t_val             r_opnd;

    // result being built
    t_val             r_res_value;
    t_key             r_res_index;
    logic             r_res_found;
    logic [7:0]       r_res_slot;
    logic [2:0]       r_res_status;

    // output register
    logic             r_out_valid;
    t_val             r_out_value;
    t_key             r_out_index;
    logic             r_out_found;
    logic [7:0]       r_out_slot;
    logic [8:0]       r_out_count;
    logic [2:0]       r_out_status;

    // ring
    t_key     key_chain [CAPACITY+1];
    t_val     val_chain [CAPACITY+1];
    logic     shift;
    t_mul_out mul_res;

    // head logic
    t_key             h_key;
    t_val             h_val;
    logic             in_acc, out_take, out_load;
    logic             is_look, is_upd, is_scale;
    logic             pos_ge_cnt, hit, full, decide, do_ins, last;
    logic             ovf, sat_now;
    logic [POS_W-1:0] last_pos;
    t_val             sum, sat_sum;
    t_key             tail_key;
    t_val             tail_val;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;
    assign out_load = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);
    assign shift    = (r_state == ST_SCAN);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            ssvs_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_key   (key_chain[g+1]),
                .i_val   (val_chain[g+1]),
                .o_key   (key_chain[g]),
                .o_val   (val_chain[g])
            );
        end
    endgenerate

    assign key_chain[CAPACITY] = tail_key;
    assign val_chain[CAPACITY] = tail_val;

    ssvs_qmul u_qmul (
        .i_clk (i_clk),
        .i_key (h_key),
        .i_a   (h_val),
        .i_b   (r_opnd),
        .o_res (mul_res)
    );

    always_comb begin
        h_key      = key_chain[0];
        h_val      = val_chain[0];
        is_look    = (r_func == FN_GET) || (r_func == FN_SET) || (r_func == FN_INC);
        is_upd     = (r_func == FN_SET) || (r_func == FN_INC);
        is_scale   = (r_func == FN_SCALE);
        pos_ge_cnt = 32'(r_pos) >= 32'(r_count);
        full       = (r_count == CNT_W'(CAPACITY));
        // first slot whose coordinate is not below the request, or the end of the list
        decide     = shift && is_look && !r_decided && (pos_ge_cnt || (h_key >= r_idx));
        hit        = !pos_ge_cnt && (h_key == r_idx);
        do_ins     = decide && !hit && is_upd && !full;
        last_pos   = is_scale ? POS_W'(CAPACITY + MUL_LAT - 1) : POS_W'(CAPACITY - 1);
        last       = (r_pos == last_pos);

        sum     = h_val + r_opnd;
        ovf     = (h_val[63] == r_opnd[63]) && (sum[63] != h_val[63]);
        sat_sum = ovf ? (h_val[63] ? VAL_MIN : VAL_MAX) : sum;

        // the multiplier output belongs to slot r_pos - MUL_LAT
        sat_now = (32'(r_pos) >= 32'(MUL_LAT))
                  && ((32'(r_pos) - 32'(MUL_LAT)) < 32'(r_count)) && mul_res.sat;

        tail_key = r_carry_on ? r_carry_key : h_key;
        tail_val = r_carry_on ? r_carry_val : h_val;
        if (is_scale) begin
            tail_key = mul_res.key;
            tail_val = mul_res.q;
        end else if (decide && hit && (r_func == FN_SET)) begin
            tail_val = r_opnd;
        end else if (decide && hit && (r_func == FN_INC)) begin
            tail_val = sat_sum;
        end else if (do_ins) begin
            tail_key = r_idx;
            tail_val = r_opnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vec_len   <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_decided   <= 1'b0;
            r_carry_on  <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vec_len <= i_cfg_wdata;
            end

            // output register: load a finished result, or drop a taken one
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_value  <= r_res_value;
                r_out_index  <= r_res_index;
                r_out_found  <= r_res_found;
                r_out_slot   <= r_res_slot;
                r_out_count  <= 9'(r_count);
                r_out_status <= r_res_status;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_func       <= i_func;
                        r_idx        <= i_index;
                        r_opnd       <= i_operand;
                        r_res_value  <= '0;
                        r_res_index  <= '0;
                        r_res_found  <= 1'b0;
                        r_res_slot   <= '0;
                        r_res_status <= STS_OK;
                        r_decided    <= 1'b0;
                        r_carry_on   <= 1'b0;
                        r_sat        <= 1'b0;
                        r_pos        <= '0;
                        priority if ((i_func == FN_GET) || (i_func == FN_SET)
                                     || (i_func == FN_INC)) begin
                            if ({1'b0, i_index} >= r_vec_len) begin
                                r_res_status <= STS_RANGE;
                                r_state      <= ST_FIN;
                            end else begin
                                r_state <= ST_SCAN;
                            end
                        end else if (i_func == FN_SCALE) begin
                            r_state <= ST_SCAN;
                        end else if (i_func == FN_CLEAR) begin
                            r_count <= '0;
                            r_state <= ST_FIN;
                        end else if (i_func == FN_READ) begin
                            if (i_index >= 32'(r_count)) begin
                                r_res_status <= STS_BADPOS;
                                r_state      <= ST_FIN;
                            end else begin
                                r_state <= ST_SCAN;
                            end
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end

                ST_SCAN: begin
                    r_pos <= r_pos + 1'b1;

                    // carry register delays every pair behind an insert by one slot
                    if (do_ins || r_carry_on) begin
                        r_carry_key <= h_key;
                        r_carry_val <= h_val;
                    end
                    if (do_ins) begin
                        r_carry_on <= 1'b1;
                        r_count    <= r_count + 1'b1;
                    end

                    if (decide) begin
                        r_decided   <= 1'b1;
                        r_res_slot  <= 8'(r_pos);
                        r_res_found <= hit;
                        priority if (r_func == FN_GET) begin
                            r_res_value <= hit ? h_val : '0;
                        end else if (hit && (r_func == FN_SET)) begin
                            r_res_value <= r_opnd;
                        end else if (hit) begin
                            r_res_value  <= sat_sum;
                            r_res_status <= ovf ? STS_SAT : STS_OK;
                        end else if (full) begin
                            r_res_status <= STS_FULL;
                        end else begin
                            r_res_value <= r_opnd;
                        end
                    end

                    if ((r_func == FN_READ) && (32'(r_pos) == r_idx)) begin
                        r_res_value <= h_val;
                        r_res_index <= h_key;
                        r_res_found <= 1'b1;
                        r_res_slot  <= r_idx[7:0];
                    end

                    if (sat_now) begin
                        r_sat <= 1'b1;
                    end

                    if (last) begin
                        r_pos   <= '0;
                        r_state <= ST_FIN;
                        // coordinate above every stored one with a full list
                        if (is_look && !r_decided && !decide) begin
                            r_res_slot   <= 8'(r_count);
                            r_res_status <= is_upd ? STS_FULL : STS_OK;
                        end
                        if (is_scale) begin
                            r_res_status <= (r_sat || sat_now) ? STS_SAT : STS_OK;
                        end
                    end
                end

                ST_FIN: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_value = $signed(r_out_value);
    assign o_result_index = r_out_index;
    assign o_found        = r_out_found;
    assign o_slot         = r_out_slot;
    assign o_entry_count  = r_out_count;
    assign o_status       = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("request taken without going busy");

    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_pos == '0))
        else $error("ring position not rewound while idle");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |-> (r_count < CNT_W'(CAPACITY)) && !r_carry_on)
        else $error("insert into a full ring or a second insert in one scan");

    a_carry_decided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_carry_on |-> r_decided)
        else $error("carry active before the insert slot was found");

endmodule
